FILE: rtl/core/ttrrs_pkg.sv
// Package for the task table round-robin scheduler.
// Holds table size, command and slot state codes, and controller/datapath types.
// No dependencies.
package ttrrs_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 6;
  localparam int ST_W      = 3;

  typedef enum logic [1:0] {
    CMD_SCHEDULE   = 2'd0,
    CMD_ALLOCATE   = 2'd1,
    CMD_SET_STATE  = 2'd2,
    CMD_READ_STATE = 2'd3
  } cmd_t;

  typedef logic [ST_W-1:0]      st_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [NUM_SLOTS-1:0] slot_vec_t;

  localparam st_t ST_EMPTY    = 3'd0;
  localparam st_t ST_CREATING = 3'd2;
  localparam st_t ST_RUNNING  = 3'd3;
  localparam st_t ST_EXECVE   = 3'd5;
  localparam st_t ST_FORK     = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic search;
    logic pick;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic is_runnable(st_t s);
    return (s == ST_RUNNING) || (s == ST_EXECVE) || (s == ST_FORK);
  endfunction

  // index of the lowest set bit; zero when none set
  function automatic idx_t first_set(slot_vec_t v);
    slot_vec_t iso;
    idx_t      r;
    iso = v & (~v + slot_vec_t'(1));
    r   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (iso[i]) r = r | idx_t'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ttrrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttrrs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ttrrs_ctrl.sv
// Sequencing controller for the scheduler: accept, search, pick, finish.
// Depends on ttrrs_pkg.
module ttrrs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ttrrs_pkg::dp_status_t status,
  output ttrrs_pkg::ctl_cmd_t   cmd,
  output logic                  in_stall
);
  import ttrrs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PICK,
    S_FINISH
  } fsm_t;

  fsm_t state_r, state_nxt;
  logic stall_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = S_PICK;
      S_PICK:   state_nxt = S_FINISH;
      S_FINISH: if (status.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.search = (state_r == S_SEARCH);
    cmd.pick   = (state_r == S_PICK);
    cmd.finish = (state_r == S_FINISH) && status.out_free;
  end

  assign in_stall = stall_r;

endmodule

FILE: rtl/core/ttrrs_dp.sv
// Datapath: slot state RAM, occupancy/runnable vectors, round-robin pick, result register.
// Depends on ttrrs_pkg and ttrrs_ram.
module ttrrs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ttrrs_pkg::cmd_t              in_command,
  input  logic [ttrrs_pkg::SLOT_W-1:0] in_slot,
  input  ttrrs_pkg::st_t               in_new_state,
  input  logic                         out_stall,
  input  ttrrs_pkg::ctl_cmd_t          cmd,
  output ttrrs_pkg::dp_status_t        status,
  output logic                         out_valid,
  output logic [ttrrs_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic                         out_success,
  output ttrrs_pkg::st_t               out_slot_state
);
  import ttrrs_pkg::*;

  // captured command
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  st_t               nst_r;

  // table state
  idx_t      cur_r, cur_nxt;
  slot_vec_t nonempty_r, nonempty_nxt;
  slot_vec_t runnable_r, runnable_nxt;

  // search candidates
  slot_vec_t hi_r, hi_nxt, lo_r, lo_nxt;

  // pending result
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_ok_r, res_ok_nxt;
  st_t               res_st_r, res_st_nxt;
  logic              res_ram_r, res_ram_nxt;
  logic              res_ne_r, res_ne_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_ok_r;
  st_t               out_st_r;

  // RAM port
  logic ram_we, ram_re;
  idx_t ram_waddr, ram_raddr;
  st_t  ram_wdata, ram_rdata;

  logic in_range;
  idx_t slot_idx;
  idx_t pick_idx;
  logic found;
  idx_t new_cur;

  ttrrs_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_range = (int'(slot_r) < NUM_SLOTS);
  assign slot_idx = idx_t'(slot_r);

  // candidate masks: slot 0 is never a candidate, in the wrap or otherwise
  always_comb begin
    slot_vec_t above, below;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      above[i] = (i > int'(cur_r)) && (i != 0);
      below[i] = (i < int'(cur_r)) && (i != 0);
    end
    if (cmd_r == CMD_ALLOCATE) begin
      hi_nxt = ~nonempty_r & ~slot_vec_t'(1);
      lo_nxt = '0;
    end else begin
      hi_nxt = runnable_r & above;
      lo_nxt = runnable_r & below;
    end
  end

  assign found    = (|hi_r) || (|lo_r);
  assign pick_idx = first_set((|hi_r) ? hi_r : lo_r);

  always_comb begin
    cur_nxt      = cur_r;
    nonempty_nxt = nonempty_r;
    runnable_nxt = runnable_r;
    res_slot_nxt = res_slot_r;
    res_ok_nxt   = res_ok_r;
    res_st_nxt   = res_st_r;
    res_ram_nxt  = res_ram_r;
    res_ne_nxt   = res_ne_r;
    ram_we       = 1'b0;
    ram_waddr    = slot_idx;
    ram_wdata    = nst_r;
    ram_re       = 1'b0;
    ram_raddr    = slot_idx;
    new_cur      = cur_r;

    if (cmd.pick) begin
      res_ram_nxt  = 1'b0;
      res_ne_nxt   = 1'b0;
      res_slot_nxt = slot_r;
      res_ok_nxt   = 1'b0;
      res_st_nxt   = ST_EMPTY;
      unique case (cmd_r)
        CMD_SCHEDULE: begin
          if (!nonempty_r[cur_r]) begin
            new_cur    = cur_r;
          end else if (found) begin
            new_cur    = pick_idx;
            res_ok_nxt = 1'b1;
          end else if (cur_r != '0) begin
            new_cur    = '0;
            res_ok_nxt = 1'b1;
          end
          cur_nxt      = new_cur;
          ram_re       = 1'b1;
          ram_raddr    = new_cur;
          res_slot_nxt = SLOT_W'(new_cur);
          res_ram_nxt  = 1'b1;
          res_ne_nxt   = nonempty_r[new_cur];
        end
        CMD_ALLOCATE: begin
          if (found) begin
            ram_we                 = 1'b1;
            ram_waddr              = pick_idx;
            ram_wdata              = ST_CREATING;
            nonempty_nxt[pick_idx] = 1'b1;
            runnable_nxt[pick_idx] = 1'b0;
            res_slot_nxt           = SLOT_W'(pick_idx);
            res_ok_nxt             = 1'b1;
            res_st_nxt             = ST_CREATING;
          end else begin
            res_slot_nxt           = '0;
          end
        end
        CMD_SET_STATE: begin
          if (in_range) begin
            ram_we                 = 1'b1;
            nonempty_nxt[slot_idx] = (nst_r != ST_EMPTY);
            runnable_nxt[slot_idx] = is_runnable(nst_r);
            res_ok_nxt             = (nst_r != ST_EMPTY);
            res_st_nxt             = nst_r;
          end
        end
        CMD_READ_STATE: begin
          if (in_range) begin
            ram_re      = 1'b1;
            res_ram_nxt = 1'b1;
            res_ne_nxt  = nonempty_r[slot_idx];
            res_ok_nxt  = nonempty_r[slot_idx];
          end
        end
        default: ;
      endcase
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      nonempty_r  <= '0;
      runnable_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      nonempty_r  <= nonempty_nxt;
      runnable_r  <= runnable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      slot_r <= in_slot;
      nst_r  <= in_new_state;
    end
    if (cmd.search) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    res_slot_r <= res_slot_nxt;
    res_ok_r   <= res_ok_nxt;
    res_st_r   <= res_st_nxt;
    res_ram_r  <= res_ram_nxt;
    res_ne_r   <= res_ne_nxt;
    if (cmd.finish) begin
      out_slot_r <= res_slot_r;
      out_ok_r   <= res_ok_r;
      // an empty slot is never trusted to the RAM contents
      out_st_r   <= res_ram_r ? (res_ne_r ? ram_rdata : ST_EMPTY) : res_st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_slot = out_slot_r;
  assign out_success     = out_ok_r;
  assign out_slot_state  = out_st_r;

endmodule

FILE: rtl/core/task_table_round_robin_scheduler.sv
// Round-robin task scheduler over a 64-entry table of 3-bit task slot states.
// The result is loaded after the input transfer through these registered steps:
// candidate masking, round-robin pick with the table update, and the
// registered read of the slot-state RAM. A new command is taken only once the
// result of the last one has been loaded; the input stalls until then.
// A result waiting in the output register does not block the next input
// transfer; only the result load waits for it to go, and the input stalls until
// then. Reset clears the table at once through per-slot occupancy bits
// (an unoccupied slot reads as empty), so there is no clearing pass.
// Depends on ttrrs_pkg, ttrrs_ctrl, ttrrs_dp, ttrrs_ram.
module task_table_round_robin_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ttrrs_pkg::cmd_t              in_command,
  input  logic [ttrrs_pkg::SLOT_W-1:0] in_slot,
  input  ttrrs_pkg::st_t               in_new_state,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ttrrs_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic                         out_success,
  output ttrrs_pkg::st_t               out_slot_state
);
  import ttrrs_pkg::*;

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  // controller: sequences one command at a time
  ttrrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (dp_status),
    .cmd      (ctl_cmd),
    .in_stall (in_stall)
  );

  // datapath: table, rotating priority pick, result register
  ttrrs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_slot         (in_slot),
    .in_new_state    (in_new_state),
    .out_stall       (out_stall),
    .cmd             (ctl_cmd),
    .status          (dp_status),
    .out_valid       (out_valid),
    .out_chosen_slot (out_chosen_slot),
    .out_success     (out_success),
    .out_slot_state  (out_slot_state)
  );

endmodule

FILE: rtl/core/ttrrs_chk.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on ttrrs_pkg and task_table_round_robin_scheduler.
module ttrrs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ttrrs_pkg::SLOT_W-1:0] out_chosen_slot,
  input logic                         out_success,
  input ttrrs_pkg::st_t               out_slot_state
);
  import ttrrs_pkg::*;

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // one command in flight: a transfer closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second command taken while one is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_chosen_slot)
      && $stable(out_success) && $stable(out_slot_state))
    else $error("stalled result changed");

  // success on a non-zero slot always names an occupied slot
  a_success_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_success && (out_chosen_slot != '0)) |-> (out_slot_state != ST_EMPTY))
    else $error("successful result names an empty slot");

endmodule

bind task_table_round_robin_scheduler ttrrs_chk u_chk (.*);
